@@ rtl/core/ssp_pkg.sv @@
package ssp_pkg;

   localparam int MAX_NODES_DEF = 64;
   localparam int MAX_EDGES_DEF = 256;

   localparam int NODE_W   = 6;
   localparam int DIST_W   = 32;
   localparam int WEIGHT_W = 16;
   localparam int NCNT_W   = 7;

   localparam logic [NCNT_W-1:0] NODE_COUNT_RESET = 7'd64;

   localparam logic signed [DIST_W-1:0] UNREACHED_DIST = 32'sd99999;
   localparam logic signed [DIST_W-1:0] DIST_MAX       = 32'sh7fff_ffff;
   localparam logic signed [DIST_W-1:0] DIST_MIN       = 32'sh8000_0000;

   localparam logic [1:0] CMD_LOAD  = 2'd0;
   localparam logic [1:0] CMD_RUN   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]                 cmd;
      logic [NODE_W-1:0]          edge_from;
      logic [NODE_W-1:0]          edge_to;
      logic signed [WEIGHT_W-1:0] edge_weight;
      logic [NODE_W-1:0]          source_node;
   } req_type;

   typedef struct packed {
      logic [NODE_W-1:0]        node_index;
      logic signed [DIST_W-1:0] distance;
      logic                     reachable;
      logic [NODE_W-1:0]        predecessor;
      logic                     has_predecessor;
      logic                     negative_cycle;
      logic                     last;
   } rsp_type;

   typedef struct packed {
      logic [NODE_W-1:0]          from;
      logic [NODE_W-1:0]          to;
      logic signed [WEIGHT_W-1:0] weight;
   } edge_type;

   typedef struct packed {
      logic                     reach;
      logic                     pred_valid;
      logic [NODE_W-1:0]        pred;
      logic signed [DIST_W-1:0] path_dist;
   } node_type;

   typedef struct packed {
      logic                     improve;
      logic signed [DIST_W-1:0] cand;
   } relax_type;

endpackage

@@ rtl/core/ssp_edge_mem.sv @@
module ssp_edge_mem
   import ssp_pkg::*;
#(
   parameter int MAX_EDGES = MAX_EDGES_DEF,
   localparam int EIW = $clog2(MAX_EDGES)
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [EIW-1:0] wr_addr,
   input  edge_type       wr_data,
   input  logic [EIW-1:0] rd_addr,
   output edge_type       rd_data
);

   edge_type mem [MAX_EDGES];
   edge_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/ssp_node_mem.sv @@
module ssp_node_mem
   import ssp_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF,
   localparam int NIW = $clog2(MAX_NODES)
) (
   input  logic           clock,
   input  logic           wr_en,
   input  logic [NIW-1:0] wr_addr,
   input  node_type       wr_data,
   input  logic [NIW-1:0] rd_addr_a,
   input  logic [NIW-1:0] rd_addr_b,
   output node_type       rd_data_a,
   output node_type       rd_data_b
);

   node_type mem [MAX_NODES];
   node_type rd_a_ff;
   node_type rd_b_ff;

   // one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

@@ rtl/core/ssp_relax_unit.sv @@
module ssp_relax_unit
   import ssp_pkg::*;
(
   input  node_type                   src,
   input  node_type                   dst,
   input  logic signed [WEIGHT_W-1:0] weight,
   output relax_type                  res
);

   logic signed [DIST_W:0]   sum;
   logic signed [DIST_W-1:0] cand;

   // saturating add, then strict compare against the destination
   always_comb begin
      sum = {src.path_dist[DIST_W-1], src.path_dist}
          + {{(DIST_W+1-WEIGHT_W){weight[WEIGHT_W-1]}}, weight};
      if (sum[DIST_W] != sum[DIST_W-1]) begin
         cand = sum[DIST_W] ? DIST_MIN : DIST_MAX;
      end else begin
         cand = sum[DIST_W-1:0];
      end
      res.cand    = cand;
      res.improve = src.reach && (!dst.reach || (cand < dst.path_dist));
   end

endmodule

@@ rtl/core/single_source_shortest_paths_top.sv @@
// single-source shortest paths over a loaded list of directed weighted edges
//
// req channel: one transaction per command. load edge and clear edge list
//   leave req_ready high, so loads stream one per cycle while the block is
//   idle. a run transaction drops req_ready until its last result is taken.
// rsp channel: a run returns one transaction per node 0..n-1, n from the
//   node_count register, with last set on node n-1.
// csr channel: writes node_count, always ready; write only while idle.
// run sequence: the node table is initialized, then for at most n passes
//   each edge in range goes through eread, nread and relax (an edge
//   outside the node range skips relax), then each result through ord,
//   oload and osend. the edge is read from the edge store, then both end
//   nodes from the node table, then the shared add/compare unit writes
//   the destination, a read-read-write chain over one node table.
// a stalled receiver simply holds the current result; nothing is lost.
// reset: edge list empty, node_count 64, block idle with no result pending;
//   edge store and node table contents are not cleared.
module single_source_shortest_paths_top
   import ssp_pkg::*;
#(
   parameter int MAX_NODES = MAX_NODES_DEF,
   parameter int MAX_EDGES = MAX_EDGES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [NCNT_W-1:0] csr_data
);

   localparam int NIW = $clog2(MAX_NODES);      // node table index
   localparam int NW  = $clog2(MAX_NODES + 1);  // node count
   localparam int EIW = $clog2(MAX_EDGES);      // edge store index
   localparam int ECW = $clog2(MAX_EDGES + 1);  // edge count

   typedef enum logic [2:0] {
      S_IDLE,
      S_INIT,
      S_EREAD,
      S_NREAD,
      S_RELAX,
      S_ORD,
      S_OLOAD,
      S_OSEND
   } state_type;

   state_type         state_ff;
   logic [NCNT_W-1:0] node_count_ff;
   logic [ECW-1:0]    edges_loaded_ff;
   logic [NW-1:0]     n_ff;
   logic [NODE_W-1:0] start_ff;
   logic              start_ok_ff;
   logic [NIW-1:0]    idx_ff;
   logic [EIW-1:0]    edge_idx_ff;
   logic [NW-1:0]     pass_ff;
   logic              changed_ff;
   logic              neg_ff;
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;

   logic [NW-1:0]  n_act;
   logic           req_fire;
   logic           edge_we;
   edge_type       edge_wdata;
   edge_type       edge_rd;
   logic           node_we;
   logic [NIW-1:0] node_waddr;
   node_type       node_wdata;
   logic [NIW-1:0] node_ra;
   logic [NIW-1:0] node_rb;
   node_type       node_rd_a;
   node_type       node_rd_b;
   relax_type      relax;
   logic           idx_last;
   logic           edge_last;
   logic           pass_last;
   logic           edge_skip;
   logic           changed_in;

   // csr: node_count register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= NODE_COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         node_count_ff <= csr_data;
      end
   end

   // active node count, zero acts as one, clipped to the table depth
   always_comb begin
      if (node_count_ff == '0) begin
         n_act = NW'(1);
      end else if (32'(node_count_ff) > MAX_NODES) begin
         n_act = NW'(MAX_NODES);
      end else begin
         n_act = NW'(node_count_ff);
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;

   // edge store: append on load, read at the current edge of the pass
   assign edge_we         = req_fire && (req_data.cmd == CMD_LOAD)
                            && (edges_loaded_ff < ECW'(MAX_EDGES));
   assign edge_wdata.from   = req_data.edge_from;
   assign edge_wdata.to     = req_data.edge_to;
   assign edge_wdata.weight = req_data.edge_weight;

   ssp_edge_mem #(
      .MAX_EDGES (MAX_EDGES)
   ) u_edge_mem (
      .clock   (clock),
      .wr_en   (edge_we),
      .wr_addr (EIW'(edges_loaded_ff)),
      .wr_data (edge_wdata),
      .rd_addr (edge_idx_ff),
      .rd_data (edge_rd)
   );

   // node table: port a reads the edge source or the node being reported,
   // port b the edge destination
   assign node_ra = (state_ff == S_NREAD) ? NIW'(edge_rd.from) : idx_ff;
   assign node_rb = NIW'(edge_rd.to);

   always_comb begin
      node_we    = 1'b0;
      node_waddr = idx_ff;
      node_wdata = '0;
      if (state_ff == S_INIT) begin
         node_we          = 1'b1;
         node_wdata.reach = start_ok_ff && (idx_ff == NIW'(start_ff));
      end else if ((state_ff == S_RELAX) && relax.improve) begin
         node_we               = 1'b1;
         node_waddr            = NIW'(edge_rd.to);
         node_wdata.reach      = 1'b1;
         node_wdata.pred_valid = 1'b1;
         node_wdata.pred       = edge_rd.from;
         node_wdata.path_dist  = relax.cand;
      end
   end

   ssp_node_mem #(
      .MAX_NODES (MAX_NODES)
   ) u_node_mem (
      .clock     (clock),
      .wr_en     (node_we),
      .wr_addr   (node_waddr),
      .wr_data   (node_wdata),
      .rd_addr_a (node_ra),
      .rd_addr_b (node_rb),
      .rd_data_a (node_rd_a),
      .rd_data_b (node_rd_b)
   );

   // shared saturating add and compare
   ssp_relax_unit u_relax (
      .src    (node_rd_a),
      .dst    (node_rd_b),
      .weight (edge_rd.weight),
      .res    (relax)
   );

   assign idx_last   = (NW'(idx_ff) == (n_ff - NW'(1)));
   assign edge_last  = (ECW'(edge_idx_ff) == (edges_loaded_ff - ECW'(1)));
   assign pass_last  = (pass_ff == (n_ff - NW'(1)));
   // edges with an end outside the node range are passed over
   assign edge_skip  = (edge_rd.from >= n_ff) || (edge_rd.to >= n_ff);
   assign changed_in = changed_ff || ((state_ff == S_RELAX) && relax.improve);

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         edges_loaded_ff <= '0;
         rsp_valid_ff    <= 1'b0;
         n_ff            <= '0;
         start_ff        <= '0;
         start_ok_ff     <= 1'b0;
         idx_ff          <= '0;
         edge_idx_ff     <= '0;
         pass_ff         <= '0;
         changed_ff      <= 1'b0;
         neg_ff          <= 1'b0;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  case (req_data.cmd)
                     CMD_LOAD: begin
                        if (edge_we) begin
                           edges_loaded_ff <= edges_loaded_ff + ECW'(1);
                        end
                     end
                     CMD_CLEAR: begin
                        edges_loaded_ff <= '0;
                     end
                     CMD_RUN: begin
                        n_ff        <= n_act;
                        start_ff    <= req_data.source_node;
                        start_ok_ff <= (req_data.source_node < n_act);
                        idx_ff      <= '0;
                        state_ff    <= S_INIT;
                     end
                     default: begin
                        // unknown command, dropped
                     end
                  endcase
               end
            end
            S_INIT: begin
               if (idx_last) begin
                  idx_ff      <= '0;
                  pass_ff     <= '0;
                  changed_ff  <= 1'b0;
                  edge_idx_ff <= '0;
                  if (edges_loaded_ff == '0) begin
                     neg_ff   <= 1'b0;
                     state_ff <= S_ORD;
                  end else begin
                     state_ff <= S_EREAD;
                  end
               end else begin
                  idx_ff <= idx_ff + NIW'(1);
               end
            end
            S_EREAD: begin
               state_ff <= S_NREAD;
            end
            S_NREAD, S_RELAX: begin
               if ((state_ff == S_NREAD) && !edge_skip) begin
                  state_ff <= S_RELAX;
               end else if (edge_last) begin
                  // end of pass
                  if (!changed_in || pass_last) begin
                     neg_ff   <= changed_in;
                     idx_ff   <= '0;
                     state_ff <= S_ORD;
                  end else begin
                     pass_ff     <= pass_ff + NW'(1);
                     changed_ff  <= 1'b0;
                     edge_idx_ff <= '0;
                     state_ff    <= S_EREAD;
                  end
               end else begin
                  changed_ff  <= changed_in;
                  edge_idx_ff <= edge_idx_ff + EIW'(1);
                  state_ff    <= S_EREAD;
               end
            end
            S_ORD: begin
               state_ff <= S_OLOAD;
            end
            S_OLOAD: begin
               rsp_data_ff.node_index      <= NODE_W'(idx_ff);
               rsp_data_ff.distance        <= node_rd_a.reach ? node_rd_a.path_dist
                                                              : UNREACHED_DIST;
               rsp_data_ff.reachable       <= node_rd_a.reach;
               rsp_data_ff.predecessor     <= node_rd_a.pred;
               rsp_data_ff.has_predecessor <= node_rd_a.pred_valid;
               rsp_data_ff.negative_cycle  <= neg_ff;
               rsp_data_ff.last            <= idx_last;
               rsp_valid_ff                <= 1'b1;
               state_ff                    <= S_OSEND;
            end
            S_OSEND: begin
               if (rsp_ready) begin
                  rsp_valid_ff <= 1'b0;
                  if (idx_last) begin
                     state_ff <= S_IDLE;
                  end else begin
                     idx_ff   <= idx_ff + NIW'(1);
                     state_ff <= S_ORD;
                  end
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

@@ rtl/core/ssp_checker.sv @@
module ssp_checker
   import ssp_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input req_type req_data,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp changed while stalled");

   // no command taken while a result is pending
   a_busy_out: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("req_ready high with result pending");

   // a run transaction makes the block busy
   a_run_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_data.cmd == CMD_RUN) |=> !req_ready)
      else $error("ready right after run");

   // last result ends the run
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_data.last |=> !rsp_valid && req_ready)
      else $error("result after last");

   // unreached nodes carry the marker distance and no predecessor
   a_unreached: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.reachable |->
         (rsp_data.distance == UNREACHED_DIST) && !rsp_data.has_predecessor)
      else $error("bad unreached result");

endmodule

bind single_source_shortest_paths_top ssp_checker u_ssp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

@@ test/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
   import ssp_pkg::*;

   // cmd value with no meaning in the block, expected to be dropped
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   // slowest run: full edge store, 64 nodes and 64 passes with no transaction;
   // the limit allows several of those
   localparam int WATCHDOG_LIMIT = 250_000;
   localparam int RANDOM_ITEMS   = 115;
   localparam int SETTLE_CYCLES  = 8;
   localparam int END_CYCLES     = 200;
   localparam int REPORT_CAP     = 60;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   req_type           req_data;
   logic              rsp_valid;
   logic              rsp_ready;
   rsp_type           rsp_data;
   logic              csr_valid;
   logic              csr_ready;
   logic [NCNT_W-1:0] csr_data;

   // predictor copy of the block state
   edge_type          arc_list [MAX_EDGES_DEF];
   int                arc_total;
   logic [NCNT_W-1:0] node_limit;

   // node reports the block still owes, oldest first
   rsp_type           node_reports_due [$];

   int                mismatch_count;
   bit                gaps_on;
   int                long_hold_cycles;

   single_source_shortest_paths_top u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // random helpers
   // ------------------------------------------------------------------

   // mostly back to back, sometimes a short gap, rarely a long one
   function automatic int pick_gap();
      int r;
      if (!gaps_on) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // node_count as the block uses it: zero acts as one, above max as max
   function automatic int active_nodes();
      if (node_limit == 0) return 1;
      if (node_limit > MAX_NODES_DEF) return MAX_NODES_DEF;
      return node_limit;
   endfunction

   // every field random, so unused fields toggle too
   function automatic req_type noise_fields(logic [1:0] cmd);
      req_type r;
      r.cmd         = cmd;
      r.edge_from   = $urandom_range(0, 63);
      r.edge_to     = $urandom_range(0, 63);
      r.edge_weight = $urandom_range(0, 65535);
      r.source_node = $urandom_range(0, 63);
      return r;
   endfunction

   // small costs with a few negative ones, some large, some full range
   function automatic logic signed [WEIGHT_W-1:0] pick_weight();
      logic signed [WEIGHT_W-1:0] w;
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) begin
         w = $urandom_range(0, 50);
         w = w - 8;
      end else if (r < 90) begin
         w = $urandom_range(0, 4000);
      end else begin
         w = $urandom_range(0, 65535);
      end
      return w;
   endfunction

   // edge mostly inside the active node range
   function automatic req_type random_edge();
      req_type r;
      int top;
      r = noise_fields(CMD_LOAD);
      top = active_nodes() - 1;
      if ($urandom_range(0, 99) < 88) begin
         r.edge_from = $urandom_range(0, top);
         r.edge_to   = $urandom_range(0, top);
      end
      r.edge_weight = pick_weight();
      return r;
   endfunction

   function automatic int pick_start();
      if ($urandom_range(0, 99) < 85) return $urandom_range(0, active_nodes() - 1);
      return $urandom_range(0, 63);
   endfunction

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // bellman-ford over the loaded edges in load order, pass count capped at n
   task automatic solve_paths(input logic [NODE_W-1:0] start);
      logic signed [DIST_W-1:0] dist_to [MAX_NODES_DEF];
      bit                       reach [MAX_NODES_DEF];
      logic [NODE_W-1:0]        pred [MAX_NODES_DEF];
      bit                       pred_ok [MAX_NODES_DEF];
      logic signed [DIST_W-1:0] cand;
      longint                   sum;
      bit                       changed;
      int                       n, a, b;
      rsp_type                  r;
      n = active_nodes();
      for (int i = 0; i < n; i++) begin
         dist_to[i] = '0;
         reach[i]   = 1'b0;
         pred[i]    = '0;
         pred_ok[i] = 1'b0;
      end
      if (start < n) reach[start] = 1'b1;
      changed = 1'b0;
      for (int pass = 0; pass < n; pass++) begin
         changed = 1'b0;
         for (int j = 0; j < arc_total; j++) begin
            a = arc_list[j].from;
            b = arc_list[j].to;
            // edges touching a node outside the range are skipped
            if (a >= n || b >= n) continue;
            if (!reach[a]) continue;
            // saturate the sum to the 32-bit signed range
            sum = longint'(dist_to[a]) + longint'(arc_list[j].weight);
            if (sum > longint'(DIST_MAX)) cand = DIST_MAX;
            else if (sum < longint'(DIST_MIN)) cand = DIST_MIN;
            else cand = sum[DIST_W-1:0];
            // only a strictly smaller value counts
            if (!reach[b] || cand < dist_to[b]) begin
               dist_to[b] = cand;
               reach[b]   = 1'b1;
               pred[b]    = a;
               pred_ok[b] = 1'b1;
               changed    = 1'b1;
            end
         end
         if (!changed) break;
      end
      // change in the last allowed pass flags a negative cycle
      for (int i = 0; i < n; i++) begin
         r.node_index      = i;
         r.distance        = reach[i] ? dist_to[i] : UNREACHED_DIST;
         r.reachable       = reach[i];
         r.predecessor     = pred[i];
         r.has_predecessor = pred_ok[i];
         r.negative_cycle  = changed;
         r.last            = (i == n - 1);
         node_reports_due  = {node_reports_due, r};
      end
   endtask

   // update the predictor with one accepted request transaction
   task automatic apply_request(input req_type item);
      case (item.cmd)
         CMD_LOAD: begin
            // a load into a full store is dropped
            if (arc_total < MAX_EDGES_DEF) begin
               arc_list[arc_total] = {item.edge_from, item.edge_to, item.edge_weight};
               arc_total++;
            end
         end
         CMD_CLEAR: begin
            arc_total = 0;
         end
         CMD_RUN: begin
            solve_paths(item.source_node);
         end
         default: begin
         end
      endcase
   endtask

   // ------------------------------------------------------------------
   // driving
   // ------------------------------------------------------------------

   // one request transaction; valid stays up so the next one can follow at once
   task automatic send_item(input req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (!req_ready);
      apply_request(item);
   endtask

   task automatic send_load(input int src, input int dst, input int cost);
      req_type r;
      r             = noise_fields(CMD_LOAD);
      r.edge_from   = src;
      r.edge_to     = dst;
      r.edge_weight = cost;
      send_item(r);
   endtask

   task automatic send_run(input int start);
      req_type r;
      r             = noise_fields(CMD_RUN);
      r.source_node = start;
      send_item(r);
   endtask

   task automatic send_clear();
      send_item(noise_fields(CMD_CLEAR));
   endtask

   // sender pauses until every owed node report has arrived
   task automatic drain_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (node_reports_due.size() != 0) @(posedge clock);
   endtask

   // node_count is only written while the block is idle
   task automatic write_node_count(input logic [NCNT_W-1:0] value);
      drain_results();
      // a trailing load or clear may still be finishing
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      node_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------
   // checking
   // ------------------------------------------------------------------

   task automatic report_mismatch(input string field, input int node, input longint got,
                                  input longint want);
      if (mismatch_count < REPORT_CAP)
         $display("%0t node %0d %s: got %0d, expected %0d", $time, node, field, got, want);
      mismatch_count++;
   endtask

   // each response transaction against the oldest owed node report
   initial begin : result_check
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            if (node_reports_due.size() == 0) begin
               report_mismatch("unexpected transaction", rsp_data.node_index,
                               longint'(rsp_data.distance), 0);
            end else begin
               want = node_reports_due.pop_front();
               if (rsp_data.node_index !== want.node_index)
                  report_mismatch("node_index", want.node_index, rsp_data.node_index,
                                  want.node_index);
               if (rsp_data.distance !== want.distance)
                  report_mismatch("distance", want.node_index, longint'(rsp_data.distance),
                                  longint'(want.distance));
               if (rsp_data.reachable !== want.reachable)
                  report_mismatch("reachable", want.node_index, rsp_data.reachable,
                                  want.reachable);
               if (rsp_data.predecessor !== want.predecessor)
                  report_mismatch("predecessor", want.node_index, rsp_data.predecessor,
                                  want.predecessor);
               if (rsp_data.has_predecessor !== want.has_predecessor)
                  report_mismatch("has_predecessor", want.node_index,
                                  rsp_data.has_predecessor, want.has_predecessor);
               if (rsp_data.negative_cycle !== want.negative_cycle)
                  report_mismatch("negative_cycle", want.node_index, rsp_data.negative_cycle,
                                  want.negative_cycle);
               if (rsp_data.last !== want.last)
                  report_mismatch("last", want.node_index, rsp_data.last, want.last);
            end
         end
      end
   end

   // receiver: random stalls, plus a long hold-off on request
   initial begin : rsp_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(negedge clock);
         if (long_hold_cycles > 0) begin
            rsp_ready <= 1'b0;
            repeat (long_hold_cycles - 1) @(negedge clock);
            long_hold_cycles = 0;
         end else if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= !reset;
            stall_left = pick_gap();
         end
      end
   end

   // ends the run when no transaction moves for too long
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("Mismatches found");
      $finish;
   end

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // chain with costs past the unreachable marker, equal-cost tie, ignored
   // command, edges outside the node range, start outside the range
   task automatic test_basic_paths();
      gaps_on = 1'b1;
      write_node_count(8);
      send_clear();
      send_load(0, 1, 5);
      send_load(1, 2, -3);
      send_load(0, 2, 10);
      send_load(0, 2, 2);           // same cost as the path via 1, no update
      send_load(2, 3, 32767);
      send_load(3, 0, -32768);
      send_load(3, 4, 32767);
      send_load(4, 5, 32767);
      send_load(5, 6, 32767);       // distance ends well above 99999
      send_load(63, 63, -1);        // outside the node range
      send_load(6, 63, 0);
      send_item(noise_fields(CMD_UNKNOWN));
      send_run(0);
      send_run(63);                 // every node unreachable
      send_run(7);                  // isolated start node
   endtask

   task automatic test_negative_cycle();
      write_node_count(4);
      send_clear();
      send_load(0, 1, -1);
      send_load(1, 0, -1);
      send_load(1, 2, 100);
      send_load(3, 3, -5);          // negative self loop
      send_run(0);
      send_run(2);                  // cycle not reachable from here
      send_run(3);
   endtask

   // node_count at zero, one and above the maximum
   task automatic test_node_count_range();
      write_node_count(0);
      send_run(0);
      send_run(1);
      write_node_count(1);
      send_run(0);
      write_node_count(7'h7f);
      send_run(63);
      send_run(0);
      write_node_count(65);
      send_run(1);
   endtask

   // fill the edge store, then loads past the end are dropped
   task automatic test_store_full();
      write_node_count(MAX_NODES_DEF);
      send_clear();
      repeat (MAX_EDGES_DEF + 2) send_item(random_edge());
      send_run(pick_start());
      write_node_count(6);
      send_run(0);
      send_load(0, 1, 1);
      send_run(0);
      send_clear();
   endtask

   // receiver holds off while the sender keeps offering, then sender pauses
   task automatic test_backpressure();
      gaps_on = 1'b1;
      write_node_count(16);
      send_clear();
      repeat (10) send_item(random_edge());
      send_run(0);
      long_hold_cycles = 400;
      repeat (8) send_item(random_edge());
      send_run(pick_start());
      drain_results();
      send_run(pick_start());
   endtask

   // mostly well-formed graphs (clear, loads, runs), some noise
   task automatic test_random_graphs();
      int sent;
      int value;
      int r;
      req_type item;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         if ($urandom_range(0, 3) == 0) begin
            r = $urandom_range(0, 99);
            if (r < 55) value = $urandom_range(2, 12);
            else if (r < 65) value = $urandom_range(0, 1);
            else if (r < 75) value = MAX_NODES_DEF;
            else if (r < 85) value = $urandom_range(65, 127);
            else value = $urandom_range(13, 63);
            write_node_count(value);
         end
         gaps_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 99) < 85) begin
            if ($urandom_range(0, 6) != 0) begin
               send_clear();
               sent++;
            end
            repeat ($urandom_range(1, 20)) begin
               if (arc_total < MAX_EDGES_DEF) sent++;
               send_item(random_edge());
            end
            repeat ($urandom_range(1, 2)) begin
               send_run(pick_start());
               sent++;
            end
         end else begin
            repeat ($urandom_range(1, 6)) begin
               item = noise_fields($urandom_range(0, 3));
               if (item.cmd == CMD_RUN || item.cmd == CMD_CLEAR ||
                   (item.cmd == CMD_LOAD && arc_total < MAX_EDGES_DEF))
                  sent++;
               send_item(item);
            end
         end
      end
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      rsp_ready        = 1'b0;
      csr_valid        = 1'b0;
      csr_data         = '0;
      mismatch_count   = 0;
      gaps_on          = 1'b1;
      long_hold_cycles = 0;
      arc_total        = 0;
      node_limit       = NODE_COUNT_RESET;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_paths();
      test_negative_cycle();
      test_node_count_range();
      test_store_full();
      test_backpressure();
      test_random_graphs();

      // all owed reports in, then a quiet stretch to catch stray ones
      drain_results();
      repeat (END_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
